/* rtl/assert_macros.svh */
// assertion macros used by depth_series_qualifier.sv
// no dependencies

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/dsq_pkg.sv */
// types and constants of the depth series qualifier
// no dependencies
`timescale 1ns / 1ps

package dsq_pkg;

	localparam int SERIES_LEN = 8;

	localparam int ADC_W    = 10;
	localparam int GAIN_W   = 20;
	localparam int OFFSET_W = 25;
	localparam int DEPTH_W  = 13;
	localparam int STATUS_W = 3;
	localparam int CFG_W    = 25;
	localparam int IDX_W    = 3;
	localparam int FRAC_W   = 16;
	localparam int PROD_W   = ADC_W + GAIN_W;
	localparam int SUM_W    = DEPTH_W + $clog2(SERIES_LEN);
	localparam int CNT_W    = $clog2(SERIES_LEN + 1);

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
	localparam logic [PROD_W:0]    TINY_Q16  = (PROD_W + 1)'(6);

	localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(355867);
	localparam logic [OFFSET_W-1:0] OFFSET_RST = OFFSET_W'(19658834);
	localparam logic [DEPTH_W-1:0]  MIN_RST    = DEPTH_W'(1);

	typedef logic [ADC_W-1:0]    adc_t;
	typedef logic [DEPTH_W-1:0]  depth_t;
	typedef logic [IDX_W-1:0]    cfg_idx_t;
	typedef logic [CFG_W-1:0]    cfg_data_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_ZERO_MIN  = 3'd1,
		ST_UNDER_MIN = 3'd2,
		ST_ABOVE_MAX = 3'd3,
		ST_SPREAD    = 3'd4
	} status_t;

	localparam cfg_idx_t REG_GAIN        = 3'd0;
	localparam cfg_idx_t REG_OFFSET      = 3'd1;
	localparam cfg_idx_t REG_MIN_EXP     = 3'd2;
	localparam cfg_idx_t REG_MAX_EXP     = 3'd3;
	localparam cfg_idx_t REG_SPREAD      = 3'd4;
	localparam cfg_idx_t REG_MEAN_CHANGE = 3'd5;

endpackage

/* rtl/dsq_if.sv */
// valid/ready channels for samples and series results
// depends on dsq_pkg
`timescale 1ns / 1ps

interface dsq_sample_if import dsq_pkg::*; ();
	logic valid;
	logic ready;
	adc_t adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

interface dsq_result_if import dsq_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t series_status;
	depth_t  mean_depth;
	logic    change_alarm;

	modport source (output valid, output series_status, output mean_depth,
		output change_alarm, input ready);
	modport sink (input valid, input series_status, input mean_depth,
		input change_alarm, output ready);
endinterface

/* rtl/depth_series_qualifier.sv */
// depth series qualifier top level; depends on dsq_pkg, dsq_if, assert_macros.svh
// path: the last sample of a series passes the input, product, statistics and result registers
// throughput: one sample per cycle; the input stalls only while a new result
// waits for an output register that still holds an untaken result
// reset: arst_n clears pipeline valids, series state, history and config to defaults
`timescale 1ns / 1ps

`include "assert_macros.svh"

module depth_series_qualifier import dsq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	dsq_sample_if.sink          samples,
	dsq_result_if.source        results,
	input  logic                cfg_we,
	input  cfg_idx_t            cfg_index,
	input  cfg_data_t           cfg_wdata
);

	logic [GAIN_W-1:0]   gain_q;
	logic [OFFSET_W-1:0] offset_q;
	depth_t              min_exp_q;
	depth_t              max_exp_q;
	depth_t              spread_q;
	depth_t              mean_change_q;

	logic                valid_s1;
	adc_t                adc_s1;
	logic                valid_s2;
	logic [PROD_W-1:0]   prod_s2;

	logic [CNT_W-1:0]    cnt_q;
	depth_t              min_q;
	depth_t              max_q;
	logic [SUM_W-1:0]    sum_q;

	logic                done_s3;
	depth_t              min_s3;
	depth_t              max_s3;
	logic [SUM_W-1:0]    sum_s3;

	depth_t              last_mean_q;
	logic                out_valid_q;
	status_t             status_q;
	depth_t              mean_q;
	logic                alarm_q;

	logic                advance;
	logic                load_out;
	logic [PROD_W:0]     v;
	logic [PROD_W-FRAC_W-1:0] v_hi;
	depth_t              depth;
	depth_t              min_nx;
	depth_t              max_nx;
	logic [SUM_W-1:0]    sum_nx;
	logic                last_sample;
	status_t             status_nx;
	logic [SUM_W-1:0]    mean_wide;
	depth_t              mean_nx;
	depth_t              diff;
	logic                alarm_nx;

	// stall only when a result would land on an untaken one
	assign advance  = !(done_s3 && out_valid_q && !results.ready);
	assign load_out = done_s3 && advance;
	assign samples.ready = advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q        <= GAIN_RST;
			offset_q      <= OFFSET_RST;
			min_exp_q     <= MIN_RST;
			max_exp_q     <= DEPTH_MAX;
			spread_q      <= DEPTH_MAX;
			mean_change_q <= DEPTH_MAX;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN:        gain_q        <= cfg_wdata[GAIN_W-1:0];
				REG_OFFSET:      offset_q      <= cfg_wdata[OFFSET_W-1:0];
				REG_MIN_EXP:     min_exp_q     <= cfg_wdata[DEPTH_W-1:0];
				REG_MAX_EXP:     max_exp_q     <= cfg_wdata[DEPTH_W-1:0];
				REG_SPREAD:      spread_q      <= cfg_wdata[DEPTH_W-1:0];
				REG_MEAN_CHANGE: mean_change_q <= cfg_wdata[DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 and 2: input register, then gain multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= samples.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			adc_s1  <= samples.adc_sample;
			prod_s2 <= PROD_W'(adc_s1) * PROD_W'(gain_q);
		end
	end

	// depth conversion and running statistics
	always_comb begin
		v    = {1'b0, prod_s2} - (PROD_W + 1)'(offset_q);
		v_hi = v[PROD_W-1:FRAC_W];
		if (v[PROD_W] || v <= TINY_Q16) begin
			depth = DEPTH_W'(1);
		end else if (v_hi > (PROD_W - FRAC_W)'(DEPTH_MAX)) begin
			depth = DEPTH_MAX;
		end else begin
			depth = v_hi[DEPTH_W-1:0];
		end
		min_nx      = (depth < min_q) ? depth : min_q;
		max_nx      = (depth > max_q) ? depth : max_q;
		sum_nx      = sum_q + SUM_W'(depth);
		last_sample = (cnt_q == CNT_W'(SERIES_LEN - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			min_q   <= DEPTH_MAX;
			max_q   <= '0;
			sum_q   <= '0;
			done_s3 <= 1'b0;
		end else if (advance) begin
			done_s3 <= valid_s2 && last_sample;
			if (valid_s2) begin
				if (last_sample) begin
					cnt_q <= '0;
					min_q <= DEPTH_MAX;
					max_q <= '0;
					sum_q <= '0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
					min_q <= min_nx;
					max_q <= max_nx;
					sum_q <= sum_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2 && last_sample) begin
			min_s3 <= min_nx;
			max_s3 <= max_nx;
			sum_s3 <= sum_nx;
		end
	end

	// series qualification
	always_comb begin
		if (min_s3 == '0) begin
			status_nx = ST_ZERO_MIN;
		end else if (min_s3 < min_exp_q) begin
			status_nx = ST_UNDER_MIN;
		end else if (max_s3 > max_exp_q) begin
			status_nx = ST_ABOVE_MAX;
		end else if ((max_s3 - min_s3) > spread_q) begin
			status_nx = ST_SPREAD;
		end else begin
			status_nx = ST_OK;
		end
		mean_wide = SUM_W'(sum_s3 / SERIES_LEN);
		mean_nx   = (mean_wide > SUM_W'(DEPTH_MAX)) ? DEPTH_MAX : mean_wide[DEPTH_W-1:0];
		diff      = (mean_nx > last_mean_q) ? (mean_nx - last_mean_q)
			: (last_mean_q - mean_nx);
		alarm_nx  = (last_mean_q != '0) && (diff > mean_change_q);
	end

	// result register and good-mean history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_mean_q <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (status_nx == ST_OK) begin
					last_mean_q <= mean_nx;
				end
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= status_nx;
			mean_q   <= (status_nx == ST_OK) ? mean_nx : '0;
			alarm_q  <= (status_nx == ST_OK) && alarm_nx;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.series_status = status_q;
	assign results.mean_depth    = mean_q;
	assign results.change_alarm  = alarm_q;

	`ASSERT_SAME(a_fail_zero, clk, arst_n, out_valid_q && status_q != ST_OK, mean_q == '0 && !alarm_q)
	`ASSERT_SAME(a_stall_why, clk, arst_n, !samples.ready, done_s3 && out_valid_q)
	`ASSERT_SAME(a_cnt_range, clk, arst_n, 1'b1, cnt_q < CNT_W'(SERIES_LEN))
	`ASSERT_NEXT(a_result_kept, clk, arst_n, done_s3 && !advance, done_s3 && out_valid_q)

endmodule
